// ===== hw/rtl/s5p_pkg.sv =====
`default_nettype none

package s5p_pkg;

  localparam logic [7:0] SOCKS_VERSION  = 8'h05;
  localparam logic [7:0] CMD_CONNECT    = 8'h01;
  localparam logic [7:0] ATYP_IPV4      = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
  localparam logic [7:0] ATYP_IPV6      = 8'h04;
  localparam logic [7:0] REPLY_NONE     = 8'h00;
  localparam logic [7:0] REPLY_GENERAL  = 8'h01;
  localparam logic [7:0] REPLY_BAD_ADDR = 8'h04;
  localparam logic [7:0] REPLY_BAD_CMD  = 8'h07;
  localparam logic [7:0] REPLY_BAD_ATYP = 8'h08;

  localparam logic [7:0] IPV4_BYTES = 8'd4;
  localparam logic [7:0] IPV6_BYTES = 8'd16;

  localparam logic [1:0] KIND_IPV4   = 2'd0;
  localparam logic [1:0] KIND_DOMAIN = 2'd1;
  localparam logic [1:0] KIND_IPV6   = 2'd2;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  typedef enum logic [1:0] {
    AT_IPV4,
    AT_DOMAIN,
    AT_IPV6,
    AT_OTHER
  } atyp_e;

  typedef enum logic [3:0] {
    ST_WAIT         = 4'd0,
    ST_GREET_OK     = 4'd1,
    ST_GREET_REJECT = 4'd2,
    ST_ADDR         = 4'd3,
    ST_ACCEPT       = 4'd4,
    ST_FAIL         = 4'd5,
    ST_PAYLOAD      = 4'd6,
    ST_NOT_SOCKS    = 4'd7,
    ST_IGNORED      = 4'd8
  } status_e;

  typedef enum logic [3:0] {
    PH_GREET_VER,
    PH_NMETHODS,
    PH_METHODS,
    PH_REQ_VER,
    PH_REQ_CMD,
    PH_REQ_RSV,
    PH_REQ_ATYP,
    PH_DOM_LEN,
    PH_ADDR,
    PH_PORT_HI,
    PH_PORT_LO,
    PH_PAYLOAD,
    PH_CLOSED
  } phase_e;

  // A received byte together with the flags the back end decides on.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       is_version;
    logic       is_zero;
    logic       is_connect;
    atyp_e      atyp;
  } cls_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] out_byte;
    logic [7:0] byte_index;
    logic [1:0] address_kind;
    logic [15:0] port_number;
    logic [7:0] reply_code;
  } res_t;

  function automatic atyp_e classify_atyp(logic [7:0] b);
    atyp_e a;
    case (b)
      ATYP_IPV4:   a = AT_IPV4;
      ATYP_DOMAIN: a = AT_DOMAIN;
      ATYP_IPV6:   a = AT_IPV6;
      default:     a = AT_OTHER;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/s5p_if.sv =====
`default_nettype none

interface s5p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       session_start;

  modport source (output valid, output in_byte, output session_start, input ready);
  modport sink (input valid, input in_byte, input session_start, output ready);
endinterface

interface s5p_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  out_byte;
  logic [7:0]  byte_index;
  logic [1:0]  address_kind;
  logic [15:0] port_number;
  logic [7:0]  reply_code;

  modport source (
    output valid, output status, output out_byte, output byte_index,
    output address_kind, output port_number, output reply_code, input ready
  );
  modport sink (
    input valid, input status, input out_byte, input byte_index,
    input address_kind, input port_number, input reply_code, output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/socks5_connect_request_parser.sv =====
// Parses the client side of a SOCKS5 session one received byte per item and gives exactly one
// result item for every byte taken. A byte with session_start set clears the parser and is read
// as the greeting version byte. The block sustains one item per clock cycle while the output is
// not stalled by rsp_o.ready; the back-end state machine decides each byte combinationally. The
// result of a byte is registered on its way to the output, passing the classification register, the
// two-entry queue and the output register. While a result waits at the output, three more bytes
// are still taken, two into the queue and one into the classification register, before the input
// stalls.
`default_nettype none

module socks5_connect_request_parser (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  s5p_in_if.sink    req_i,
  s5p_out_if.source rsp_o
);

  s5p_pkg::cls_t front_cls;
  logic          front_valid;
  logic          front_ready;
  s5p_pkg::cls_t back_cls;
  logic          back_valid;
  logic          back_ready;

  s5p_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cls_o       (front_cls),
    .cls_valid_o (front_valid),
    .cls_ready_i (front_ready)
  );

  s5p_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_cls),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_cls),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  s5p_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_i       (back_cls),
    .cls_valid_i (back_valid),
    .cls_ready_o (back_ready),
    .rsp_o       (rsp_o)
  );

  a_accept_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == 4'(s5p_pkg::ST_ACCEPT)) |-> (rsp_o.port_number != 16'd0))
    else $error("accepted request with a zero port");

  a_fail_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == 4'(s5p_pkg::ST_FAIL)) |->
      (rsp_o.reply_code == s5p_pkg::REPLY_GENERAL || rsp_o.reply_code == s5p_pkg::REPLY_BAD_ADDR ||
       rsp_o.reply_code == s5p_pkg::REPLY_BAD_CMD || rsp_o.reply_code == s5p_pkg::REPLY_BAD_ATYP))
    else $error("failure without a valid reply code");

  a_byte_only_when_passed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != 4'(s5p_pkg::ST_ADDR) &&
     rsp_o.status != 4'(s5p_pkg::ST_PAYLOAD)) |-> (rsp_o.out_byte == 8'd0))
    else $error("byte passed on with a status that carries none");

endmodule

`default_nettype wire

// ===== hw/rtl/s5p_front.sv =====
`default_nettype none

module s5p_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  s5p_in_if.sink            req_i,
  output s5p_pkg::cls_t     cls_o,
  output logic              cls_valid_o,
  input  wire logic         cls_ready_i
);

  logic          valid_q;
  s5p_pkg::cls_t cls_d;
  s5p_pkg::cls_t cls_q;

  always_comb begin
    cls_d.data       = req_i.in_byte;
    cls_d.start      = req_i.session_start;
    cls_d.is_version = (req_i.in_byte == s5p_pkg::SOCKS_VERSION);
    cls_d.is_zero    = (req_i.in_byte == 8'd0);
    cls_d.is_connect = (req_i.in_byte == s5p_pkg::CMD_CONNECT);
    cls_d.atyp       = s5p_pkg::classify_atyp(req_i.in_byte);
  end

  assign req_i.ready = !valid_q || cls_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      cls_q <= cls_d;
    end
  end

  assign cls_o       = cls_q;
  assign cls_valid_o = valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/s5p_queue.sv =====
`default_nettype none

module s5p_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire s5p_pkg::cls_t push_data_i,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  output s5p_pkg::cls_t      pop_data_o,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i
);

  localparam int unsigned PtrW = s5p_pkg::QPTR_W;
  localparam logic [PtrW-1:0] LastIdx = PtrW'(s5p_pkg::QDEPTH - 1);

  s5p_pkg::cls_t   entries_q [s5p_pkg::QDEPTH];
  logic [PtrW-1:0] wptr_q;
  logic [PtrW-1:0] rptr_q;
  logic [PtrW:0]   cnt_q;
  logic            push;
  logic            pop;

  assign push_ready_o = (cnt_q != (PtrW + 1)'(s5p_pkg::QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entries_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == LastIdx) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == LastIdx) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/s5p_back.sv =====
`default_nettype none

module s5p_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire s5p_pkg::cls_t cls_i,
  input  wire logic          cls_valid_i,
  output logic               cls_ready_o,
  s5p_out_if.source          rsp_o
);

  s5p_pkg::phase_e phase_q, phase_d;
  logic [7:0]      methods_left_q, methods_left_d;
  logic            no_auth_q, no_auth_d;
  logic [7:0]      pending_q, pending_d;
  logic [1:0]      kind_q, kind_d;
  logic [7:0]      bytes_left_q, bytes_left_d;
  logic [7:0]      addr_pos_q, addr_pos_d;
  logic [7:0]      port_hi_q, port_hi_d;
  logic            ovalid_q;
  s5p_pkg::res_t   res_d;
  s5p_pkg::res_t   res_q;
  logic            take;

  assign cls_ready_o = !ovalid_q || rsp_o.ready;
  assign take        = cls_valid_i && cls_ready_o;

  always_comb begin
    s5p_pkg::phase_e cur_phase;
    logic [7:0]      cur_ml;
    logic            cur_na;
    logic [7:0]      cur_pend;
    logic [1:0]      cur_kind;
    logic [7:0]      cur_bl;
    logic [7:0]      cur_pos;
    logic [7:0]      cur_hi;
    logic [7:0]      ml_dec;
    logic [7:0]      bl_dec;
    logic            na_new;
    logic [15:0]     port;

    // A new session starts from the cleared state before its byte is decided.
    cur_phase = cls_i.start ? s5p_pkg::PH_GREET_VER : phase_q;
    cur_ml    = cls_i.start ? 8'd0 : methods_left_q;
    cur_na    = cls_i.start ? 1'b0 : no_auth_q;
    cur_pend  = cls_i.start ? s5p_pkg::REPLY_NONE : pending_q;
    cur_kind  = cls_i.start ? s5p_pkg::KIND_IPV4 : kind_q;
    cur_bl    = cls_i.start ? 8'd0 : bytes_left_q;
    cur_pos   = cls_i.start ? 8'd0 : addr_pos_q;
    cur_hi    = cls_i.start ? 8'd0 : port_hi_q;
    ml_dec    = cur_ml - 8'd1;
    bl_dec    = cur_bl - 8'd1;
    na_new    = cur_na || cls_i.is_zero;
    port      = {cur_hi, cls_i.data};

    phase_d        = cur_phase;
    methods_left_d = cur_ml;
    no_auth_d      = cur_na;
    pending_d      = cur_pend;
    kind_d         = cur_kind;
    bytes_left_d   = cur_bl;
    addr_pos_d     = cur_pos;
    port_hi_d      = cur_hi;
    res_d          = '0;
    res_d.status   = s5p_pkg::ST_WAIT;

    case (cur_phase)
      s5p_pkg::PH_GREET_VER: begin
        if (cls_i.is_version) begin
          phase_d = s5p_pkg::PH_NMETHODS;
        end else begin
          res_d.status = s5p_pkg::ST_NOT_SOCKS;
          phase_d      = s5p_pkg::PH_CLOSED;
        end
      end
      s5p_pkg::PH_NMETHODS: begin
        methods_left_d = cls_i.data;
        no_auth_d      = 1'b0;
        if (cls_i.is_zero) begin
          res_d.status = s5p_pkg::ST_GREET_REJECT;
          phase_d      = s5p_pkg::PH_CLOSED;
        end else begin
          phase_d = s5p_pkg::PH_METHODS;
        end
      end
      s5p_pkg::PH_METHODS: begin
        no_auth_d      = na_new;
        methods_left_d = ml_dec;
        if (ml_dec == 8'd0) begin
          if (na_new) begin
            res_d.status = s5p_pkg::ST_GREET_OK;
            phase_d      = s5p_pkg::PH_REQ_VER;
          end else begin
            res_d.status = s5p_pkg::ST_GREET_REJECT;
            phase_d      = s5p_pkg::PH_CLOSED;
          end
        end
      end
      s5p_pkg::PH_REQ_VER: begin
        pending_d = cls_i.is_version ? s5p_pkg::REPLY_NONE : s5p_pkg::REPLY_GENERAL;
        phase_d   = s5p_pkg::PH_REQ_CMD;
      end
      s5p_pkg::PH_REQ_CMD: begin
        if (cur_pend == s5p_pkg::REPLY_NONE && !cls_i.is_connect) begin
          pending_d = s5p_pkg::REPLY_BAD_CMD;
        end
        phase_d = s5p_pkg::PH_REQ_RSV;
      end
      s5p_pkg::PH_REQ_RSV: begin
        phase_d = s5p_pkg::PH_REQ_ATYP;
      end
      s5p_pkg::PH_REQ_ATYP: begin
        addr_pos_d = 8'd0;
        if (cur_pend != s5p_pkg::REPLY_NONE) begin
          res_d.status     = s5p_pkg::ST_FAIL;
          res_d.reply_code = cur_pend;
          phase_d          = s5p_pkg::PH_CLOSED;
        end else begin
          case (cls_i.atyp)
            s5p_pkg::AT_IPV4: begin
              kind_d       = s5p_pkg::KIND_IPV4;
              bytes_left_d = s5p_pkg::IPV4_BYTES;
              phase_d      = s5p_pkg::PH_ADDR;
            end
            s5p_pkg::AT_DOMAIN: begin
              kind_d  = s5p_pkg::KIND_DOMAIN;
              phase_d = s5p_pkg::PH_DOM_LEN;
            end
            s5p_pkg::AT_IPV6: begin
              kind_d       = s5p_pkg::KIND_IPV6;
              bytes_left_d = s5p_pkg::IPV6_BYTES;
              phase_d      = s5p_pkg::PH_ADDR;
            end
            default: begin
              res_d.status     = s5p_pkg::ST_FAIL;
              res_d.reply_code = s5p_pkg::REPLY_BAD_ATYP;
              phase_d          = s5p_pkg::PH_CLOSED;
            end
          endcase
        end
      end
      s5p_pkg::PH_DOM_LEN: begin
        bytes_left_d = cls_i.data;
        phase_d      = cls_i.is_zero ? s5p_pkg::PH_PORT_HI : s5p_pkg::PH_ADDR;
      end
      s5p_pkg::PH_ADDR: begin
        res_d.status       = s5p_pkg::ST_ADDR;
        res_d.out_byte     = cls_i.data;
        res_d.byte_index   = cur_pos;
        res_d.address_kind = cur_kind;
        addr_pos_d         = cur_pos + 8'd1;
        bytes_left_d       = bl_dec;
        if (bl_dec == 8'd0) begin
          phase_d = s5p_pkg::PH_PORT_HI;
        end
      end
      s5p_pkg::PH_PORT_HI: begin
        port_hi_d = cls_i.data;
        phase_d   = s5p_pkg::PH_PORT_LO;
      end
      s5p_pkg::PH_PORT_LO: begin
        if (port == 16'd0 || (cur_kind == s5p_pkg::KIND_DOMAIN && cur_pos == 8'd0)) begin
          res_d.status     = s5p_pkg::ST_FAIL;
          res_d.reply_code = s5p_pkg::REPLY_BAD_ADDR;
          phase_d          = s5p_pkg::PH_CLOSED;
        end else begin
          res_d.status       = s5p_pkg::ST_ACCEPT;
          res_d.address_kind = cur_kind;
          res_d.port_number  = port;
          phase_d            = s5p_pkg::PH_PAYLOAD;
        end
      end
      s5p_pkg::PH_PAYLOAD: begin
        res_d.status   = s5p_pkg::ST_PAYLOAD;
        res_d.out_byte = cls_i.data;
      end
      default: begin
        res_d.status = s5p_pkg::ST_IGNORED;
        phase_d      = s5p_pkg::PH_CLOSED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= s5p_pkg::PH_GREET_VER;
      methods_left_q <= '0;
      no_auth_q      <= 1'b0;
      pending_q      <= s5p_pkg::REPLY_NONE;
      kind_q         <= s5p_pkg::KIND_IPV4;
      bytes_left_q   <= '0;
      addr_pos_q     <= '0;
      port_hi_q      <= '0;
    end else if (take) begin
      phase_q        <= phase_d;
      methods_left_q <= methods_left_d;
      no_auth_q      <= no_auth_d;
      pending_q      <= pending_d;
      kind_q         <= kind_d;
      bytes_left_q   <= bytes_left_d;
      addr_pos_q     <= addr_pos_d;
      port_hi_q      <= port_hi_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cls_ready_o) begin
      ovalid_q <= cls_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.valid        = ovalid_q;
  assign rsp_o.status       = res_q.status;
  assign rsp_o.out_byte     = res_q.out_byte;
  assign rsp_o.byte_index   = res_q.byte_index;
  assign rsp_o.address_kind = res_q.address_kind;
  assign rsp_o.port_number  = res_q.port_number;
  assign rsp_o.reply_code   = res_q.reply_code;

endmodule

`default_nettype wire
